>>> src/cat_pkg.sv
// ---------------------------------------------------------------------------
// cat_pkg - shared types and constants for the CORDIC atan2 pipeline
// Datapath widths, the vector bundle carried between stages, and the
// arctangent step table (8192 = pi/2).
// ---------------------------------------------------------------------------
`default_nettype none

package cat_pkg;

	localparam int InW  = 16;  // input component width
	localparam int XyW  = 19;  // internal x/y width, covers CORDIC gain
	localparam int ZW   = 16;  // angle accumulator width
	localparam int AngW = 15;  // output angle width
	localparam int TableLen = 13;

	localparam logic signed [ZW-1:0] QUARTER_TURN = 16'sd8192;

	localparam logic signed [ZW-1:0] ATAN_TABLE [0:TableLen-1] = '{
		16'sd4096, 16'sd2418, 16'sd1278, 16'sd649, 16'sd326, 16'sd163, 16'sd81,
		16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1
	};

	typedef struct packed {
		logic signed [XyW-1:0] x;
		logic signed [XyW-1:0] y;
		logic signed [ZW-1:0]  z;
	} cat_vec_t;

endpackage

`default_nettype wire

>>> src/cordic_atan2_angle.sv
// ---------------------------------------------------------------------------
// cordic_atan2_angle - four-quadrant angle of a 16-bit vector by CORDIC
// Pre-rotation stage for x < 0, then one register stage per micro-rotation.
// ---------------------------------------------------------------------------
//
//  channel  | dir | width | content (low bit first)
//  ---------+-----+-------+--------------------------------------------
//  s_axis   | in  | 32    | y_in[15:0], x_in[31:16], signed
//  m_axis   | out | 16    | angle[14:0] signed (16384 = pi), bit 15 zero
//
//  One quarter-turn pre-rotation stage and one stage per micro-rotation.
//  One request enters per cycle while the first stage has room.
//  Each stage holds its own valid bit and frees itself when empty or when the
//  next stage takes its content, so bubbles close up under a stall.
//  arst_n clears all valid bits at once; datapath registers are not reset.
//  The output register is the last stage; a held result does not stop intake
//  while earlier stages have room.
// ---------------------------------------------------------------------------
`default_nettype none

module cordic_atan2_angle #(
	parameter int ITERATIONS = 13  // 1..13 micro-rotations
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // y_in[15:0], x_in[31:16]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata    // angle[14:0], zero pad [15]
);
	import cat_pkg::*;

	logic signed [InW-1:0] y_in;
	logic signed [InW-1:0] x_in;
	logic signed [XyW-1:0] y_ext;
	logic signed [XyW-1:0] x_ext;
	cat_vec_t              pre_vec;

	logic                  pre_vld_s0;
	cat_vec_t              pre_vec_s0;
	logic                  pre_rdy;

	// chain links: index 0 is the pre-rotation output, ITERATIONS the last stage
	logic     chain_vld [0:ITERATIONS];
	logic     chain_rdy [0:ITERATIONS];
	cat_vec_t chain_vec [0:ITERATIONS];

	assign y_in  = s_axis_tdata[InW-1:0];
	assign x_in  = s_axis_tdata[2*InW-1:InW];
	assign y_ext = XyW'(y_in);
	assign x_ext = XyW'(x_in);

	// quarter turn for the left half plane; y == 0 goes the negative way
	always_comb begin
		if (x_in < 0) begin
			if (y_in > 0) begin
				pre_vec.x = y_ext;
				pre_vec.y = -x_ext;
				pre_vec.z = QUARTER_TURN;
			end else begin
				pre_vec.x = -y_ext;
				pre_vec.y = x_ext;
				pre_vec.z = -QUARTER_TURN;
			end
		end else begin
			pre_vec.x = x_ext;
			pre_vec.y = y_ext;
			pre_vec.z = '0;
		end
	end

	assign pre_rdy       = !pre_vld_s0 || chain_rdy[0];
	assign s_axis_tready = pre_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s0 <= 1'b0;
		end else if (pre_rdy) begin
			pre_vld_s0 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (pre_rdy && s_axis_tvalid) begin
			pre_vec_s0 <= pre_vec;
		end
	end

	assign chain_vld[0] = pre_vld_s0;
	assign chain_vec[0] = pre_vec_s0;

	// micro-rotation stages, shift amount equals the step number
	for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
		cat_stage #(
			.SHIFT (i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (chain_vld[i]),
			.in_rdy  (chain_rdy[i]),
			.in_vec  (chain_vec[i]),
			.out_vld (chain_vld[i+1]),
			.out_rdy (chain_rdy[i+1]),
			.out_vec (chain_vec[i+1])
		);
	end

	assign chain_rdy[ITERATIONS] = m_axis_tready;

	// angle wraps modulo 32768: keep the low 15 bits
	assign m_axis_tvalid = chain_vld[ITERATIONS];
	assign m_axis_tdata  = {1'b0, chain_vec[ITERATIONS].z[AngW-1:0]};

endmodule

`default_nettype wire

>>> src/cat_stage.sv
// ---------------------------------------------------------------------------
// cat_stage - one CORDIC vectoring micro-rotation with its pipeline register
// Drives y toward zero by a shift of SHIFT bits and accumulates the step
// angle; registered output with valid and per-stage ready.
// ---------------------------------------------------------------------------
`default_nettype none

module cat_stage #(
	parameter int SHIFT = 0
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_vld,
	output logic              in_rdy,
	input  cat_pkg::cat_vec_t in_vec,
	output logic              out_vld,
	input  wire               out_rdy,
	output cat_pkg::cat_vec_t out_vec
);
	import cat_pkg::*;

	logic                  vld_si;
	cat_vec_t              vec_si;
	cat_vec_t              nxt_vec;
	logic signed [XyW-1:0] xs;
	logic signed [XyW-1:0] ys;

	// stage slot frees when empty or when its content moves on
	assign in_rdy = !vld_si || out_rdy;

	always_comb begin
		xs = in_vec.x >>> SHIFT;
		ys = in_vec.y >>> SHIFT;
		if (in_vec.y < 0) begin
			nxt_vec.x = in_vec.x - ys;
			nxt_vec.y = in_vec.y + xs;
			nxt_vec.z = in_vec.z - ATAN_TABLE[SHIFT];
		end else begin
			nxt_vec.x = in_vec.x + ys;
			nxt_vec.y = in_vec.y - xs;
			nxt_vec.z = in_vec.z + ATAN_TABLE[SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_si <= 1'b0;
		end else if (in_rdy) begin
			vld_si <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			vec_si <= nxt_vec;
		end
	end

	assign out_vld = vld_si;
	assign out_vec = vec_si;

endmodule

`default_nettype wire

>>> src/cat_checker.sv
// ---------------------------------------------------------------------------
// cat_checker - port-level checks for cordic_atan2_angle
// Watches handshakes and output shape; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module cat_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata
);

	// no result is offered while in reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

	// an empty or draining output means the pipe can take a request
	a_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("intake blocked while output drains");

	// pad bit above the 15-bit angle stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[15])
		else $error("tdata pad bit set");

	// a stalled result stays offered with the same value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result dropped or changed");

endmodule

bind cordic_atan2_angle cat_checker u_cat_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
